/* hw/rtl/lvps_pkg.sv */
// Package: shared constants, stack command codes and status struct.
`default_nettype none
package lvps_pkg;

    localparam int LEN_W = 11;
    localparam logic [7:0] OPEN_CODE = 8'd40;

    typedef logic [2:0] t_stack_op;
    localparam t_stack_op OP_NONE  = 3'd0;
    localparam t_stack_op OP_PUSH  = 3'd1;
    localparam t_stack_op OP_POP   = 3'd2;
    localparam t_stack_op OP_BASE  = 3'd3;
    localparam t_stack_op OP_CLEAR = 3'd4;

    typedef struct packed {
        logic full;
        logic has_below;
    } t_stack_stat;

endpackage
`default_nettype wire

/* hw/rtl/lvps_if.sv */
// Interfaces: input byte channel and result channel.
`default_nettype none
interface lvps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface lvps_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] max_length;
    logic        too_long;

    modport source (output valid, output max_length, output too_long, input ready);
    modport sink   (input valid, input max_length, input too_long, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lvps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lvps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/lvps_stack.sv */
// Position stack: top, next-below and base in registers, deeper entries in RAM.
`default_nettype none
module lvps_stack
    import lvps_pkg::*;
#(
    parameter int DEPTH = 1025,
    parameter int DW    = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_stack_op   i_op,
    input  wire logic [DW-1:0] i_data,
    output      logic [DW-1:0] o_below,
    output      t_stack_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0] r_count;
    logic [DW-1:0] r_top;
    logic [DW-1:0] r_below;
    logic [DW-1:0] r_base;
    logic          r_pend;

    logic [DW-1:0] ram_rdata;
    logic [DW-1:0] below_eff;
    logic [CW-1:0] rd_idx;
    logic          we;

    // Forward the entry fetched by the previous pop.
    assign below_eff = r_pend ? ram_rdata : r_below;
    assign o_below   = below_eff;

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.has_below = (r_count >= CW'(2));

    assign rd_idx = r_count - CW'(3);
    assign we     = (i_op == OP_PUSH) && !o_stat.full;

    lvps_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_data),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_top   <= '0;
            r_base  <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (i_op)
                OP_PUSH: begin
                    if (!o_stat.full) begin
                        r_below <= r_top;
                        r_top   <= i_data;
                        r_count <= r_count + CW'(1);
                        r_pend  <= 1'b0;
                    end else if (r_pend) begin
                        r_below <= ram_rdata;
                        r_pend  <= 1'b0;
                    end
                end
                OP_POP: begin
                    r_top   <= below_eff;
                    r_count <= r_count - CW'(1);
                    if (r_count == CW'(3)) begin
                        r_below <= r_base;
                        r_pend  <= 1'b0;
                    end else begin
                        r_pend  <= (r_count > CW'(3));
                    end
                end
                OP_BASE: begin
                    r_count <= CW'(1);
                    r_top   <= i_data;
                    r_base  <= i_data;
                    r_pend  <= 1'b0;
                end
                OP_CLEAR: begin
                    r_count <= CW'(1);
                    r_top   <= '0;
                    r_base  <= '0;
                    r_pend  <= 1'b0;
                end
                default: begin
                    if (r_pend) begin
                        r_below <= ram_rdata;
                        r_pend  <= 1'b0;
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0)
        else $error("stack lost its base entry");

    a_pend_deep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_count >= CW'(3))
        else $error("pending fetch on a shallow stack");

    a_clear_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_CLEAR |=> r_count == CW'(1) && r_top == '0 && !r_pend)
        else $error("clear did not restore the sentinel");
`endif

endmodule
`default_nettype wire

/* hw/rtl/longest_valid_parens_stack.sv */
// Top level: streaming longest valid bracket substring over a position stack.
`default_nettype none
// Takes a string one byte per item on i_in, byte 40 being an opening bracket
// and every other byte a closing one, and gives one result on o_out for the
// byte flagged is_last: the length of the longest valid bracket substring and
// a too_long flag when the string ran past MAX_LEN bytes (only the first
// MAX_LEN bytes are scanned). The block takes one item per clock cycle. The
// positions live in a (MAX_LEN+1)-word RAM with a registered read;
// the top of stack, the entry below it and the base entry sit in registers,
// and each pop prefetches the next deeper entry so that it is ready on the
// following cycle. After reset and after each string the stack is restored
// from registers, so no clearing pass is needed. The result sits in an output
// register; i_in.ready drops only while a result waits there and o_out.ready
// is low, so the input side keeps moving as long as results are taken.
module longest_valid_parens_stack
    import lvps_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lvps_in_if.sink         i_in,
    lvps_out_if.source      o_out
);

    localparam int PW = $clog2(MAX_LEN + 1);

    logic [PW-1:0]    r_pos;
    logic [PW-1:0]    r_best;
    logic             r_ovf;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_ovf;

    logic [PW-1:0]    n_pos;
    logic [PW-1:0]    n_best;
    logic             n_ovf;

    logic             in_acc;
    logic             at_limit;
    logic             is_open;
    logic [PW-1:0]    stored;
    logic [PW-1:0]    below;
    logic [PW-1:0]    len;
    t_stack_op        stack_op;
    t_stack_stat      stack_stat;

    // Accept while the result slot is free or being drained this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.max_length = r_out_len;
    assign o_out.too_long   = r_out_ovf;

    assign at_limit = (r_pos >= PW'(MAX_LEN));
    assign is_open  = (i_in.char_code == OPEN_CODE);
    // Positions are kept plus one so the sentinel reads as zero.
    assign stored   = r_pos + PW'(1);
    assign len      = stored - below;

    lvps_stack #(
        .DEPTH (MAX_LEN + 1),
        .DW    (PW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stack_op),
        .i_data  (stored),
        .o_below (below),
        .o_stat  (stack_stat)
    );

    always_comb begin
        stack_op = OP_NONE;
        n_pos    = r_pos;
        n_best   = r_best;
        n_ovf    = r_ovf;
        if (in_acc) begin
            if (at_limit) begin
                // Past the limit: drop the byte, remember the overflow.
                n_ovf = 1'b1;
            end else begin
                n_pos = stored;
                if (is_open) begin
                    stack_op = stack_stat.full ? OP_NONE : OP_PUSH;
                end else if (stack_stat.has_below) begin
                    // Pop; the entry beneath becomes the new top.
                    stack_op = OP_POP;
                    if (below <= stored && len > r_best) begin
                        n_best = len;
                    end
                end else begin
                    // Unmatched closer: it becomes the new base.
                    stack_op = OP_BASE;
                end
            end
            if (i_in.is_last) begin
                stack_op = OP_CLEAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && i_in.is_last) begin
                r_out_valid <= 1'b1;
                r_pos       <= '0;
                r_best      <= '0;
                r_ovf       <= 1'b0;
            end else begin
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                r_pos  <= n_pos;
                r_best <= n_best;
                r_ovf  <= n_ovf;
            end
        end
    end

    // Result payload: load on the last byte of a string.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.is_last) begin
            r_out_len <= LEN_W'(n_best);
            r_out_ovf <= n_ovf;
        end
    end

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_LEN))
        else $error("position ran past the limit");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= r_pos)
        else $error("best length exceeds bytes scanned");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.is_last |=> o_out.valid && r_pos == '0 && r_best == '0)
        else $error("last byte did not emit and restart");
`endif

endmodule
`default_nettype wire

/* verif/paren_score_pkg.sv */
// Scoreboard class: predicts the longest valid bracket span of each string and checks results.
package paren_score_pkg;
    import lvps_pkg::*;

    localparam int STRING_CAP = 1024;

    typedef struct packed {
        logic [LEN_W-1:0] max_length;
        logic             too_long;
    } span_result_t;

    class paren_span_scoreboard;
        logic [LEN_W-1:0] pos_stack [STRING_CAP+1];
        int unsigned      stack_fill;   // entries including the base sentinel
        int unsigned      scan_pos;     // bytes scanned in the current string
        logic [LEN_W-1:0] best_span;
        logic             clipped;
        span_result_t     spans_due[$];
        int unsigned      error_count;

        function new();
            error_count = 0;
            restart();
        endfunction

        function void restart();
            pos_stack[0] = '0;
            stack_fill   = 1;
            scan_pos     = 0;
            best_span    = '0;
            clipped      = 1'b0;
        endfunction

        function void push_pos(logic [LEN_W-1:0] mark);
            if (stack_fill < STRING_CAP + 1) begin
                pos_stack[stack_fill] = mark;
                stack_fill++;
            end
        endfunction

        // Advance the prediction by one accepted byte; queue a result on the last one.
        function void note_byte(logic [7:0] code, logic last);
            logic [LEN_W-1:0] mark;
            logic [LEN_W-1:0] top;
            span_result_t     due;
            if (scan_pos >= STRING_CAP) begin
                clipped = 1'b1;
            end else begin
                mark = LEN_W'(scan_pos + 1);
                if (code == OPEN_CODE) begin
                    push_pos(mark);
                end else begin
                    if (stack_fill > 0) stack_fill--;
                    if (stack_fill > 0) begin
                        top = pos_stack[stack_fill-1];
                        if (top <= mark && (mark - top) > best_span) best_span = mark - top;
                    end else begin
                        push_pos(mark);
                    end
                end
                scan_pos++;
            end
            if (last) begin
                due.max_length = best_span;
                due.too_long   = clipped;
                spans_due.push_back(due);
                restart();
            end
        endfunction

        function void check_result(logic [LEN_W-1:0] max_length, logic too_long);
            span_result_t want;
            if (spans_due.size() == 0) begin
                $display("%0t ns: unexpected result: expected none, got max_length=%0d too_long=%0b",
                         $time, max_length, too_long);
                error_count++;
                return;
            end
            want = spans_due.pop_front();
            if (want.max_length !== max_length) begin
                $display("%0t ns: max_length mismatch: expected %0d, got %0d",
                         $time, want.max_length, max_length);
                error_count++;
            end
            if (want.too_long !== too_long) begin
                $display("%0t ns: too_long mismatch: expected %0b, got %0b",
                         $time, want.too_long, too_long);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return spans_due.size();
        endfunction
    endclass
endpackage

/* verif/testbench.sv */
// Top testbench: drives bracket strings into the block and scores its span results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lvps_pkg::*;
    import paren_score_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 750;
    localparam int SETTLE_CYCLES = 16;

    typedef logic [7:0] char_seq_t[$];

    logic i_clk;
    logic i_rst_n;

    lvps_in_if  byte_ch ();
    lvps_out_if span_ch ();

    longest_valid_parens_stack #(
        .MAX_LEN(STRING_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (span_ch)
    );

    paren_span_scoreboard span_board = new();

    int unsigned cycle_count = 0;
    bit          steady_tx = 1'b0;  // sender gives no gaps while set
    bit          steady_rx = 1'b0;  // receiver starts no new stalls while set
    int unsigned rx_hold = 0;

    // 20 ns clock: low half, then high half.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Stall length: mostly short, now and then long.
    function automatic int stall_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int byte_gap();
        if (steady_tx || $urandom_range(0, 99) < 70) return 0;
        return stall_len();
    endfunction

    // Any byte other than an opening bracket closes.
    function automatic logic [7:0] closer();
        logic [7:0] code;
        code = 8'($urandom_range(0, 255));
        if (code == OPEN_CODE) code = ~code;
        return code;
    endfunction

    // Result side: change ready at the falling edge; hold it low for a stall, then release.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            span_ch.ready = 1'b0;
            rx_hold--;
        end else if (steady_rx || $urandom_range(0, 3) != 0) begin
            span_ch.ready = 1'b1;
        end else begin
            span_ch.ready = 1'b0;
            rx_hold = stall_len() - 1;
        end
    end

    // Score every result taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && span_ch.valid && span_ch.ready) begin
            span_board.check_result(span_ch.max_length, span_ch.too_long);
        end
    end

    // Drive one byte from a falling edge and hold it until the block takes it.
    // Return at the falling edge after the handshake, with valid still high.
    task automatic send_byte(input logic [7:0] code, input logic last);
        int gap;
        gap = byte_gap();
        if (gap > 0) begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.char_code = code;
        byte_ch.is_last   = last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        span_board.note_byte(code, last);
        @(negedge i_clk);
    endtask

    // Send a whole string; flag its final byte as last.
    task automatic send_string(input char_seq_t text);
        foreach (text[k]) send_byte(text[k], k == text.size() - 1);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain();
        byte_ch.valid = 1'b0;
        while (span_board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly balanced strings with random content and stray closers; the rest pure noise.
    task automatic make_random_text(output char_seq_t text);
        int len;
        int depth;
        int shape;
        text  = {};
        shape = $urandom_range(0, 9);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 20);
        depth = 0;
        for (int k = 0; k < len; k++) begin
            if (shape >= 7) begin
                text.push_back($urandom_range(0, 1) ? OPEN_CODE : closer());
            end else if (depth == 0) begin
                if ($urandom_range(0, 9) != 0) begin
                    text.push_back(OPEN_CODE);
                    depth++;
                end else begin
                    text.push_back(closer());
                end
            end else if (len - k <= depth || $urandom_range(0, 1) == 0) begin
                text.push_back(closer());
                depth--;
            end else begin
                text.push_back(OPEN_CODE);
                depth++;
            end
        end
    endtask

    // Stimulus.
    initial begin
        char_seq_t text;
        int        sent;

        byte_ch.valid     = 1'b0;
        byte_ch.char_code = '0;
        byte_ch.is_last   = 1'b0;
        span_ch.ready     = 1'b0;
        i_rst_n           = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: lone closer, lone opener, minimal pair, unmatched opener in front,
        // stray closers around pairs, nesting after a pair, closer before opener.
        send_string('{8'd255});
        send_string('{OPEN_CODE});
        send_string('{OPEN_CODE, 8'd0});
        send_string('{OPEN_CODE, OPEN_CODE, 8'd41});
        send_string('{8'd41, OPEN_CODE, 8'd41, OPEN_CODE, 8'd41, 8'd41});
        send_string('{OPEN_CODE, 8'd41, OPEN_CODE, OPEN_CODE, 8'd39, 8'd255});
        send_string('{8'd128, OPEN_CODE});

        // Pause until the directed results are all back.
        drain();

        // Random strings with shifting idle patterns on both sides.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            steady_tx = ($urandom_range(0, 7) == 0);
            steady_rx = ($urandom_range(0, 7) == 0);
            make_random_text(text);
            send_string(text);
            sent += text.size();
            if ($urandom_range(0, 29) == 0) drain();
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        drain();

        // Full-length nesting: deep stack, back-to-back unwinding to the widest span,
        // then a few bytes past the cap with the last byte beyond it.
        text = {};
        for (int k = 0; k < STRING_CAP / 2; k++) text.push_back(OPEN_CODE);
        for (int k = 0; k < STRING_CAP / 2; k++) text.push_back(closer());
        for (int k = 0; k < 5; k++) text.push_back($urandom_range(0, 1) ? OPEN_CODE : closer());
        steady_tx = 1'b1;
        send_string(text);
        steady_tx = 1'b0;

        // Wind down: wait for the last results, then let the block settle.
        byte_ch.valid = 1'b0;
        while (span_board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (span_board.error_count == 0 && span_board.pending() == 0) begin
            $display("longest_valid_parens_stack verification clean");
        end else begin
            $display("longest_valid_parens_stack verification failed");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
        $display("longest_valid_parens_stack verification failed");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/lvps_pkg.sv
hw/rtl/lvps_if.sv
hw/rtl/lvps_ram.sv
hw/rtl/lvps_stack.sv
hw/rtl/longest_valid_parens_stack.sv
verif/paren_score_pkg.sv
verif/testbench.sv
